@@ src/avws_pkg.sv @@
// Shared widths, constants, codes and controller/datapath interface types for the window meter.
package avws_pkg;

  // field and register widths
  localparam int SAMPLE_W  = 12;
  localparam int CFG_W     = 10;
  localparam int CV_W      = 10;
  localparam int COUNT_W   = 10;
  localparam int SUM_W     = 22;
  localparam int SQSUM_W   = 35;
  localparam int REG_IDX_W = 2;

  // derived datapath widths
  localparam int N_W      = COUNT_W + 1;        // sample count incl. a full wrap
  localparam int SQFS_W   = SQSUM_W + CFG_W;    // sum of squares times full scale
  localparam int PROD_W   = SQFS_W + CFG_W;     // sum of squares times full scale squared
  localparam int SUMFS_W  = SUM_W + CFG_W;      // code sum times full scale
  localparam int CODEFS_W = SAMPLE_W + CFG_W;   // one code times full scale
  localparam int DMEAN_W  = 22;                 // N * 4095
  localparam int FSQ_W    = 25;                 // holds 4095^2
  localparam int DRMS_W   = 35;                 // N * 4095^2
  localparam int REM_W    = 35;                 // divider remainder, below the divisor
  localparam int QW_RMS   = 20;                 // quotient bits of the mean square
  localparam int QW_SMALL = 10;                 // quotient bits of a plain reading
  localparam int DQ_W     = QW_RMS;             // divider dividend/quotient shifter
  localparam int ROOT_W   = CV_W;
  localparam int CNT_W    = 5;

  localparam logic [SAMPLE_W-1:0] CODE_FULL    = 12'd4095;
  localparam logic [FSQ_W-1:0]    CODE_FULL_SQ = 25'd16769025;
  localparam logic [CFG_W-1:0]    WIN_RESET    = 10'd100;
  localparam logic [CFG_W-1:0]    FS_RESET     = 10'd330;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE = 2'd1;

  // divisions run one after another on the shared divider
  typedef enum logic {
    OP_RMS   = 1'b0,
    OP_MEAN  = 1'b1
  } div_op_t;

  typedef struct packed {
    logic    take;
    logic    snap;
    logic    mul1;
    logic    mul2;
    logic    div_load;
    logic    div_step;
    logic    div_store;
    logic    sqrt_step;
    logic    out_load;
    div_op_t op;
  } cmd_t;

  typedef struct packed {
    logic closing;
  } stat_t;

endpackage

@@ src/ac_voltage_window_stats_unit.sv @@
// Top level of the windowed RMS / mean / min / max voltage meter.
//
// Input channel: one 12-bit ADC code per word on sample, in_valid / in_stall.
// Output channel: one word per window (rms, mean, min, max and swing, all in
// hundredths of a volt), out_valid / out_stall.
// Config port: cfg_we with cfg_addr 0 = window length, 1 = full scale; write
// only while no window result is pending.
// Samples are accepted one per cycle, save a closing word that waits as below.
// The word that closes a window is snapshotted and the accumulators restart
// at once; the result is worked out by the two product stages, the shared
// restoring divider (20 quotient bits for the mean square, 10 for the mean,
// each with a load and a store step) and the bit-serial square root of 10
// root bits; min, max and swing come straight off their products.
// A closing word arriving while the previous window is still being worked out
// is stalled.
// A finished word waits in the output register while out_stall is high, and
// the next window keeps accumulating behind it.
// Reset (rst, synchronous) restores window length 100 and full scale 330,
// empties the window and drops any pending result.
module ac_voltage_window_stats_unit import avws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CV_W-1:0]      rms_centivolts,
  output logic [CV_W-1:0]      mean_centivolts,
  output logic [CV_W-1:0]      min_centivolts,
  output logic [CV_W-1:0]      max_centivolts,
  output logic [CV_W-1:0]      swing_centivolts
);

  cmd_t  cmd;
  stat_t stat;

  avws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  avws_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .sample           (sample),
    .cmd              (cmd),
    .stat             (stat),
    .rms_centivolts   (rms_centivolts),
    .mean_centivolts  (mean_centivolts),
    .min_centivolts   (min_centivolts),
    .max_centivolts   (max_centivolts),
    .swing_centivolts (swing_centivolts)
  );

endmodule

@@ src/avws_datapath.sv @@
// Datapath: config registers, window accumulators, snapshot, multipliers, divider and root unit.
module avws_datapath import avws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [SAMPLE_W-1:0]  sample,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic [CV_W-1:0]      rms_centivolts,
  output logic [CV_W-1:0]      mean_centivolts,
  output logic [CV_W-1:0]      min_centivolts,
  output logic [CV_W-1:0]      max_centivolts,
  output logic [CV_W-1:0]      swing_centivolts
);

  logic [CFG_W-1:0]    win;
  logic [CFG_W-1:0]    fs;
  logic [CFG_W-1:0]    need;

  logic [COUNT_W-1:0]  taken;
  logic [SUM_W-1:0]    sum;
  logic [SQSUM_W-1:0]  sumsq;
  logic [SAMPLE_W-1:0] lo;
  logic [SAMPLE_W-1:0] hi;

  logic [N_W-1:0]        count_inc;
  logic [2*SAMPLE_W-1:0] sample_sq;
  logic [SUM_W-1:0]      sum_acc;
  logic [SQSUM_W-1:0]    sumsq_acc;
  logic [SAMPLE_W-1:0]   lo_acc;
  logic [SAMPLE_W-1:0]   hi_acc;

  logic [N_W-1:0]      snap_n;
  logic [SUM_W-1:0]    snap_sum;
  logic [SQSUM_W-1:0]  snap_sq;
  logic [SAMPLE_W-1:0] snap_lo;
  logic [SAMPLE_W-1:0] snap_hi;

  logic [SQFS_W-1:0]   sqfs;
  logic [DRMS_W-1:0]   drms;
  logic [DMEAN_W-1:0]  dmean;
  logic [PROD_W-1:0]   prod;
  logic [SUMFS_W-1:0]  sumfs;
  logic [CODEFS_W-1:0] lofs;
  logic [CODEFS_W-1:0] hifs;
  logic [CODEFS_W-1:0] swfs;

  logic [REM_W-1:0]    ld_rem;
  logic [DQ_W-1:0]     ld_dq;
  logic [REM_W-1:0]    ld_div;

  logic [REM_W-1:0]    rem;
  logic [DQ_W-1:0]     dq;
  logic [REM_W-1:0]    dvs;
  logic [REM_W:0]      trial_rem;
  logic [REM_W:0]      diff_rem;
  logic                ge;

  logic [DQ_W-1:0]     qrms;
  logic [CV_W-1:0]     res_mean;
  logic [CV_W-1:0]     res_min;
  logic [CV_W-1:0]     res_max;
  logic [CV_W-1:0]     res_swing;

  logic [ROOT_W-1:0]   root;
  logic [ROOT_W-1:0]   smask;
  logic [ROOT_W-1:0]   trial_root;
  logic [2*ROOT_W-1:0] trial_sq;

  // floor(x / 4095) for quotients under 4096; 4095 is one short of 2^12,
  // so x + (x >> 12) + 1, shifted down 12, gives it exactly
  function automatic logic [CV_W-1:0] div_code_full(input logic [CODEFS_W-1:0] x);
    logic [CODEFS_W:0] t;
    t = {1'b0, x} + (CODEFS_W+1)'(x >> SAMPLE_W) + (CODEFS_W+1)'(1);
    return t[SAMPLE_W +: CV_W];
  endfunction

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= WIN_RESET;
      fs  <= FS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WINDOW_LEN: win <= cfg_wdata;
        REG_FULL_SCALE: fs  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a zero window length behaves as one
  assign need      = (win == '0) ? CFG_W'(1) : win;
  assign count_inc = {1'b0, taken} + N_W'(1);
  assign stat.closing = (count_inc >= {1'b0, need});

  // accumulator update for the incoming word
  assign sample_sq = sample * sample;
  assign sum_acc   = sum + SUM_W'(sample);
  assign sumsq_acc = sumsq + SQSUM_W'(sample_sq);
  assign lo_acc    = (sample < lo) ? sample : lo;
  assign hi_acc    = (sample > hi) ? sample : hi;

  always_ff @(posedge clk) begin
    if (rst || cmd.snap) begin
      taken <= '0;
      sum   <= '0;
      sumsq <= '0;
      lo    <= CODE_FULL;
      hi    <= '0;
    end else if (cmd.take) begin
      taken <= count_inc[COUNT_W-1:0];
      sum   <= sum_acc;
      sumsq <= sumsq_acc;
      lo    <= lo_acc;
      hi    <= hi_acc;
    end
  end

  // snapshot of the closed window, closing word included
  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      snap_n   <= count_inc;
      snap_sum <= sum_acc;
      snap_sq  <= sumsq_acc;
      snap_lo  <= lo_acc;
      snap_hi  <= hi_acc;
    end
  end

  // two product stages, registered between
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      sqfs  <= SQFS_W'(snap_sq) * SQFS_W'(fs);
      drms  <= DRMS_W'(snap_n) * DRMS_W'(CODE_FULL_SQ);
      dmean <= DMEAN_W'(snap_n) * DMEAN_W'(CODE_FULL);
    end
    if (cmd.mul2) begin
      prod  <= PROD_W'(sqfs) * PROD_W'(fs);
      sumfs <= SUMFS_W'(snap_sum) * SUMFS_W'(fs);
      lofs  <= CODEFS_W'(snap_lo) * CODEFS_W'(fs);
      hifs  <= CODEFS_W'(snap_hi) * CODEFS_W'(fs);
      swfs  <= CODEFS_W'(snap_hi - snap_lo) * CODEFS_W'(fs);
    end
  end

  // single-code readings straight off their products
  assign res_min   = div_code_full(lofs);
  assign res_max   = div_code_full(hifs);
  assign res_swing = div_code_full(swfs);

  // divider operands: remainder starts at dividend >> quotient bits
  always_comb begin
    unique case (cmd.op)
      OP_RMS: begin
        ld_rem = prod[PROD_W-1:QW_RMS];
        ld_dq  = prod[QW_RMS-1:0];
        ld_div = drms;
      end
      OP_MEAN: begin
        ld_rem = REM_W'(sumfs[SUMFS_W-1:QW_SMALL]);
        ld_dq  = {sumfs[QW_SMALL-1:0], {(DQ_W-QW_SMALL){1'b0}}};
        ld_div = REM_W'(dmean);
      end
    endcase
  end

  // restoring divider, one quotient bit a cycle
  assign trial_rem = {rem, dq[DQ_W-1]};
  assign diff_rem  = trial_rem - {1'b0, dvs};
  assign ge        = (trial_rem >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= ld_rem;
      dq  <= ld_dq;
      dvs <= ld_div;
    end else if (cmd.div_step) begin
      rem <= ge ? diff_rem[REM_W-1:0] : trial_rem[REM_W-1:0];
      dq  <= {dq[DQ_W-2:0], ge};
    end
  end

  // file each quotient
  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      unique case (cmd.op)
        OP_RMS:  qrms     <= dq;
        OP_MEAN: res_mean <= dq[CV_W-1:0];
      endcase
    end
  end

  // integer square root of the mean square, one root bit a cycle
  assign trial_root = root | smask;
  assign trial_sq   = trial_root * trial_root;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      root  <= '0;
      smask <= {1'b1, {(ROOT_W-1){1'b0}}};
    end else if (cmd.sqrt_step) begin
      if (trial_sq <= qrms) begin
        root <= trial_root;
      end
      smask <= smask >> 1;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rms_centivolts   <= root;
      mean_centivolts  <= res_mean;
      min_centivolts   <= res_min;
      max_centivolts   <= res_max;
      swing_centivolts <= res_swing;
    end
  end

endmodule

@@ src/avws_ctrl.sv @@
// Controller: input stall, end-of-window sequencing of the shared units, output valid.
module avws_ctrl import avws_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output logic  in_stall,
  output logic  out_valid,
  output cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL1   = 8'b0000_0010,
    S_MUL2   = 8'b0000_0100,
    S_DLOAD  = 8'b0000_1000,
    S_DRUN   = 8'b0001_0000,
    S_DSTORE = 8'b0010_0000,
    S_SQRT   = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t           state;
  state_t           state_next;
  div_op_t          op;
  div_op_t          op_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             busy;
  logic             take;
  logic             out_free;

  // a closing word waits while the previous window is still being worked out
  assign busy     = (state != S_IDLE);
  assign in_stall = busy && stat.closing;
  assign take     = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next    = state;
    op_next       = op;
    cnt_next      = cnt;
    cmd           = '0;
    cmd.op        = op;
    cmd.take      = take;
    cmd.snap      = take && stat.closing;
    unique case (state)
      S_IDLE: begin
        if (cmd.snap) begin
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        op_next    = OP_RMS;
        state_next = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        cnt_next     = (op == OP_RMS) ? CNT_W'(QW_RMS - 1) : CNT_W'(QW_SMALL - 1);
        state_next   = S_DRUN;
      end
      S_DRUN: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_DSTORE;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        if (op == OP_MEAN) begin
          cnt_next   = CNT_W'(ROOT_W - 1);
          state_next = S_SQRT;
        end else begin
          op_next    = OP_MEAN;
          state_next = S_DLOAD;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_OUT;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_RMS;
      cnt   <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      cnt   <= cnt_next;
    end
  end

  // output word valid: set on load, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ src/avws_checker.sv @@
// Port-level checker for the window meter and its bind to the top level.
module avws_checker import avws_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_stall,
  input logic [CV_W-1:0] rms_centivolts,
  input logic [CV_W-1:0] mean_centivolts,
  input logic [CV_W-1:0] min_centivolts,
  input logic [CV_W-1:0] max_centivolts,
  input logic [CV_W-1:0] swing_centivolts
);

  // reset drops any pending result word
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word still valid after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rms_centivolts) &&
      $stable(mean_centivolts) && $stable(min_centivolts) &&
      $stable(max_centivolts) && $stable(swing_centivolts))
    else $error("stalled result word changed");

  // true RMS is never below the mean, the mean never below the minimum
  a_rms_mean_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rms_centivolts >= mean_centivolts) &&
      (mean_centivolts >= min_centivolts))
    else $error("rms, mean and minimum out of order");

  // the mean sits under the maximum, and the swing never exceeds it
  a_max_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (max_centivolts >= mean_centivolts) &&
      (swing_centivolts <= max_centivolts))
    else $error("maximum below mean or swing above maximum");

endmodule

bind ac_voltage_window_stats_unit avws_checker u_avws_checker (.*);
